FILE: src/tcw_pkg.sv
package tcw_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_SEND    = 2'd2;

  // ACK classes reported with each result
  localparam logic [1:0] CLASS_NEW  = 2'd0;
  localparam logic [1:0] CLASS_DUP  = 2'd1;
  localparam logic [1:0] CLASS_NONE = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DUP_ACK_LIMIT  = 1'd1;
  localparam int CFG_DATA_W = 16;

  // Reset values and fixed limits
  localparam logic [15:0] THR_RESET       = 16'd64;
  localparam logic [15:0] THR_MIN         = 16'd2;
  localparam logic [15:0] THR_MAX         = 16'hFFFF;
  localparam logic [16:0] FR_INFLATE      = 17'd3;
  localparam logic [3:0]  DUP_LIMIT_RESET = 4'd3;
  localparam logic [7:0]  DUP_MAX         = 8'd255;
  localparam logic [14:0] PEER_WIN_RESET  = 15'd1;

  // Queue between classifier and executor
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_SLOW_START = 2'd0,
    PH_AVOIDANCE  = 2'd1,
    PH_RECOVERY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    OP_NEW,
    OP_DUP,
    OP_TIMEOUT,
    OP_SEND,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_EXEC,
    BS_DIV
  } back_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ack_flag;
    logic [31:0] ack_number;
    logic [14:0] peer_window;
  } in_item_t;

  typedef struct packed {
    logic [14:0] send_window;
    logic [31:0] congestion_window;
    logic [15:0] threshold;
    logic [1:0]  phase;
    logic [1:0]  ack_class;
  } out_item_t;

  // One classified event waiting for the executor
  typedef struct packed {
    op_t         op;
    logic [14:0] peer_window;
  } entry_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage

FILE: src/tcw_in_if.sv
interface tcw_in_if;
  import tcw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/tcw_out_if.sv
interface tcw_out_if;
  import tcw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/tcp_congestion_window_control.sv
// Reno-style congestion window controller.
// events: one word per ACK received, timeout or packet sent (valid/ready).
// results: one word per event with send window, congestion window (Q16.16
//   by default, FRAC_BITS fraction bits), threshold, phase and ACK class.
// cfg: write port, index 0 initial threshold (also loads the threshold),
//   index 1 duplicate ACK limit; write only while no event is in flight.
// An accepted event is written into the queue, popped into the executor
//   once the output register is free, and its result loaded into the output
//   register. A new ACK or a send in congestion avoidance first runs the
//   reciprocal divider, one quotient bit a cycle, before the result is loaded.
// The executor works on one event at a time.
// A two-word queue sits between the classifier and the executor, so events
//   keep being accepted while a result waits; when the receiver stalls the
//   result holds in the output register and the queue fills, then events
//   ready drops. Reset state: window 1.0, threshold 64, slow start.
module tcp_congestion_window_control #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data,
  tcw_in_if.sink                             events,
  tcw_out_if.source                          results
);
  import tcw_pkg::*;

  cfg_write_t cfg;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       queue_full;
  logic       head_valid;
  entry_t     head;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .events     (events),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  tcw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );
endmodule

FILE: src/tcw_queue.sv
module tcw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcw_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output tcw_pkg::entry_t head
);
  import tcw_pkg::*;

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

FILE: src/tcw_front.sv
module tcw_front (
  input  logic            clk,
  input  logic            rst,
  tcw_in_if.sink          events,
  input  logic            queue_full,
  output logic            push,
  output tcw_pkg::entry_t push_entry
);
  import tcw_pkg::*;

  logic [31:0] ack_base;
  logic [14:0] peer_window;
  logic        is_new;
  logic        is_dup;

  assign events.ready = !queue_full;
  assign push         = events.valid && !queue_full;

  // ACK classification against the send base
  assign is_new = (events.data.kind == KIND_ACK) && events.data.ack_flag
                  && (events.data.ack_number > ack_base);
  assign is_dup = (events.data.kind == KIND_ACK) && events.data.ack_flag
                  && (events.data.ack_number == ack_base);

  always_comb begin
    push_entry.peer_window = (is_new || is_dup) ? events.data.peer_window : peer_window;
    priority if (is_new) begin
      push_entry.op = OP_NEW;
    end else if (is_dup) begin
      push_entry.op = OP_DUP;
    end else if (events.data.kind == KIND_TIMEOUT) begin
      push_entry.op = OP_TIMEOUT;
    end else if (events.data.kind == KIND_SEND) begin
      push_entry.op = OP_SEND;
    end else begin
      push_entry.op = OP_NONE;
    end
  end

  // send base and advertised window
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_base    <= '0;
      peer_window <= PEER_WIN_RESET;
    end else if (push) begin
      if (is_new) begin
        ack_base <= events.data.ack_number;
      end
      peer_window <= push_entry.peer_window;
    end
  end
endmodule

FILE: src/tcw_recip.sv
module tcw_recip #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        divisor,
  output logic               done,
  output logic [FRAC_BITS:0] quotient
);
  // 2^(2F) / divisor, one quotient bit a cycle; divisor is at least 2^F
  localparam int STEPS = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic [32:0]       shifted;
  logic              take;

  assign shifted = {rem, 1'b0};
  assign take    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring step
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 32'd1 << (FRAC_BITS - 1);
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
      quotient <= {quotient[FRAC_BITS-1:0], take};
    end
  end
endmodule

FILE: src/tcw_back.sv
module tcw_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::cfg_write_t cfg,
  input  logic                head_valid,
  input  tcw_pkg::entry_t     head,
  output logic                pop,
  tcw_out_if.source           results
);
  import tcw_pkg::*;

  localparam logic [31:0] WIN_ONE = 32'd1 << FRAC_BITS;

  back_state_t          state;
  back_state_t          state_next;
  entry_t               cur;
  phase_t               phase;
  phase_t               phase_next;
  logic [31:0]          window;
  logic [31:0]          window_next;
  logic [15:0]          thr;
  logic [15:0]          thr_next;
  logic [7:0]           dup;
  logic [7:0]           dup_next;
  logic [3:0]           dup_limit;
  logic                 out_valid;
  out_item_t            out_next;
  logic                 out_load;
  logic                 div_start;
  logic                 div_done;
  logic [FRAC_BITS:0]   div_q;

  logic [7:0]           dup_eff;
  logic                 dup_hit;
  logic [31:0]          half_raw;
  logic [15:0]          half;
  logic                 win_ge_thr;
  logic [31:0]          win_plus_one;
  logic [31:0]          win_plus_recip;
  logic [31:0]          win_rule;
  logic [15:0]          thr_rule;
  logic [31:0]          whole;
  logic                 is_new;
  logic                 is_to;

  // saturating integer to window format
  function automatic logic [31:0] to_win(input logic [16:0] n);
    logic [47:0] wide;
    wide = {31'd0, n} << FRAC_BITS;
    to_win = (wide > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  tcw_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (window),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared terms of the phase rules
  assign is_new   = (cur.op == OP_NEW);
  assign is_to    = (cur.op == OP_TIMEOUT);
  assign dup_eff  = is_new ? 8'd0
                  : (cur.op == OP_DUP && dup != DUP_MAX) ? dup + 8'd1 : dup;
  assign dup_hit  = (dup_eff >= {4'd0, dup_limit});
  assign half_raw = window >> (FRAC_BITS + 1);
  assign half     = (half_raw > 32'd65535) ? THR_MAX : half_raw[15:0];
  assign win_ge_thr     = ({16'd0, window} >= ({32'd0, thr} << FRAC_BITS));
  assign win_plus_one   = sat_add(window, WIN_ONE);
  assign win_plus_recip = sat_add(window, 32'(div_q));

  // next state and datapath
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    phase_next  = phase;
    window_next = window;
    thr_next    = thr;
    dup_next    = dup;
    win_rule    = window;
    thr_rule    = thr;
    unique case (state)
      BS_IDLE: begin
        if (head_valid && (!out_valid || results.ready)) begin
          pop        = 1'b1;
          state_next = BS_EXEC;
        end
      end
      BS_EXEC: begin
        dup_next   = dup_eff;
        state_next = BS_IDLE;
        out_load   = 1'b1;
        unique case (cur.op)
          OP_NEW, OP_DUP, OP_TIMEOUT: begin
            unique case (phase)
              PH_SLOW_START: begin
                priority if (win_ge_thr) begin
                  phase_next = PH_AVOIDANCE;
                end else if (dup_hit) begin
                  thr_rule   = half;
                  win_rule   = to_win({1'b0, half} + FR_INFLATE);
                  phase_next = PH_RECOVERY;
                end else if (is_to) begin
                  thr_rule = half;
                  win_rule = to_win({1'b0, half});
                  dup_next = '0;
                end
              end
              PH_AVOIDANCE: begin
                priority if (dup_hit) begin
                  thr_rule   = half;
                  win_rule   = to_win({1'b0, half} + FR_INFLATE);
                  phase_next = PH_RECOVERY;
                end else if (is_new) begin
                  div_start  = 1'b1;
                  out_load   = 1'b0;
                  state_next = BS_DIV;
                end else if (is_to) begin
                  thr_rule   = half;
                  win_rule   = to_win({1'b0, half});
                  dup_next   = '0;
                  phase_next = PH_SLOW_START;
                end
              end
              PH_RECOVERY: begin
                priority if (dup_hit) begin
                  win_rule = win_plus_one;
                end else if (is_new) begin
                  win_rule   = to_win({1'b0, thr});
                  dup_next   = '0;
                  phase_next = PH_AVOIDANCE;
                end else if (is_to) begin
                  thr_rule   = half;
                  win_rule   = to_win({1'b0, half});
                  dup_next   = '0;
                  phase_next = PH_SLOW_START;
                end
              end
              default: ;
            endcase
          end
          OP_SEND: begin
            if (phase == PH_SLOW_START) begin
              win_rule = win_plus_one;
            end else if (phase == PH_AVOIDANCE) begin
              div_start  = 1'b1;
              out_load   = 1'b0;
              state_next = BS_DIV;
            end
          end
          default: ;
        endcase
        // floors on threshold and window
        thr_next    = (thr_rule < THR_MIN) ? THR_MIN : thr_rule;
        window_next = (win_rule < WIN_ONE) ? WIN_ONE : win_rule;
      end
      BS_DIV: begin
        if (div_done) begin
          window_next = win_plus_recip;
          out_load    = 1'b1;
          state_next  = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  // result word
  assign whole = window_next >> FRAC_BITS;
  always_comb begin
    out_next.send_window       = (whole < {17'd0, cur.peer_window}) ? whole[14:0]
                                                                      : cur.peer_window;
    out_next.congestion_window = window_next;
    out_next.threshold         = thr_next;
    out_next.phase             = phase_next;
    unique case (cur.op)
      OP_NEW:  out_next.ack_class = CLASS_NEW;
      OP_DUP:  out_next.ack_class = CLASS_DUP;
      default: out_next.ack_class = CLASS_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // congestion state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SLOW_START;
      window    <= WIN_ONE;
      thr       <= THR_RESET;
      dup       <= '0;
      dup_limit <= DUP_LIMIT_RESET;
    end else begin
      phase  <= phase_next;
      window <= window_next;
      dup    <= dup_next;
      if (cfg.we && cfg.index == CFG_INIT_THRESHOLD) begin
        thr <= (cfg.data < THR_MIN) ? THR_MIN : cfg.data;
      end else begin
        thr <= thr_next;
      end
      if (cfg.we && cfg.index == CFG_DUP_ACK_LIMIT) begin
        dup_limit <= cfg.data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.data <= out_next;
    end
  end

  assign results.valid = out_valid;
endmodule
